// ===== src/mrt_pkg.sv =====
`default_nettype none
package mrt_pkg;
    localparam int TABLE_ENTRIES_DEF = 32;
    localparam int NUM_PORTS_DEF     = 8;
    localparam logic [11:0] VLAN_MASK = 12'hFFF;

    typedef enum logic [2:0] {
        CMD_ADD    = 3'd0,
        CMD_DEL    = 3'd1,
        CMD_REPL   = 3'd2,
        CMD_FLUSH  = 3'd3,
        CMD_COUNT  = 3'd4,
        CMD_SETP   = 3'd5,
        CMD_BAD6   = 3'd6,
        CMD_BAD7   = 3'd7
    } t_cmd;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_UNREG     = 2'd3;

    typedef struct packed {
        logic [1:0]  status;
        logic [2:0]  out_port;
        logic [11:0] out_vlan;
        logic [7:0]  port_mask;
        logic        last;
    } t_res;
endpackage
`default_nettype wire

// ===== src/mrt_out_reg.sv =====
`default_nettype none
// One-entry output register between engine and master side.
module mrt_out_reg (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_valid,
    output logic           o_ready,
    input  mrt_pkg::t_res  i_res,
    input  wire [5:0]      i_count,
    output logic           o_valid,
    input  wire            i_ready,
    output mrt_pkg::t_res  o_res,
    output logic [5:0]     o_count
);
    logic r_valid;
    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            o_res   <= i_res;
            o_count <= i_count;
        end
    end
endmodule
`default_nettype wire

// ===== src/multicast_replication_table.sv =====
// Flow: add, delete and replicate scan every table entry (S_SCAN), then decide (S_ACT); the result
//   passes through the output register. Other commands go straight to S_ACT. A replicate hit
//   then checks each port (S_REPL) and emits its copies (S_EMIT), one per cycle unless the output stalls.
// Commands: one at a time; a new command is taken only in S_IDLE, once the last result of the
//   previous command has been taken by the output register.
// Reset: synchronous active low; clears valid bits, port tables and count, not key/mask memories.
`default_nettype none
module multicast_replication_table #(
    parameter int TABLE_ENTRIES = mrt_pkg::TABLE_ENTRIES_DEF,
    parameter int NUM_PORTS     = mrt_pkg::NUM_PORTS_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: mac_addr[47:0], vlan_id[59:48], port[62:60], src_mac[110:63],
    //        priv_vlan[122:111], zero pad to 128
    input  wire [127:0] s_axis_tdata,
    // tuser: command[2:0]
    input  wire [2:0]   s_axis_tuser,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // tdata: status[1:0], out_port[4:2], out_vlan[16:5], port_mask[24:17],
    //        use_count[30:25], zero pad to 32
    output logic [31:0] m_axis_tdata,
    output logic        m_axis_tlast
);
    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam int PL = (NUM_PORTS < 8) ? NUM_PORTS : 8;
    localparam int PW = (PL > 1) ? $clog2(PL) : 1;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SCAN = 5'b00010,
        S_ACT  = 5'b00100,
        S_REPL = 5'b01000,
        S_EMIT = 5'b10000
    } t_state;

    // entry memories: key and mask, one read port, registered read
    logic [59:0] r_key_mem [TABLE_ENTRIES];
    logic [7:0]  r_msk_mem [TABLE_ENTRIES];
    logic [59:0] r_key_q;
    logic [7:0]  r_msk_q;
    logic [TABLE_ENTRIES-1:0] r_vld;
    // only ports below PL (NUM_PORTS, at most 8) are addressable, so the port tables stop there
    logic [47:0] r_pmac [PL];
    logic [11:0] r_pvlan [PL];

    t_state      r_state;
    mrt_pkg::t_cmd r_cmd;
    logic [59:0] r_key;
    logic [2:0]  r_port;
    logic [47:0] r_src;
    logic [11:0] r_pv;
    logic [CW-1:0] r_ctr, r_rd;      // read address issued / entry checked
    logic        r_hit, r_free_ok;
    logic [IW-1:0] r_hit_i, r_free_i;
    logic [CW-1:0] r_used;
    logic [7:0]  r_mask, r_sel;
    logic [3:0]  r_pi;
    logic        r_rdv;

    logic          ob_ready;
    logic          e_valid;
    mrt_pkg::t_res e_res;
    mrt_pkg::t_res o_res;
    logic [5:0]    o_cnt;
    logic          port_ok;

    assign port_ok = 32'(r_port) < PL;
    assign s_axis_tready = (r_state == S_IDLE);

    // pending selection: lowest set bit of r_sel at or above r_pi
    logic [7:0] rem;
    logic [2:0] nxt;
    logic       more;
    always_comb begin
        rem = r_sel & ~((8'd1 << r_pi[2:0]) - 8'd1);
        if (r_pi[3]) rem = 8'd0;
        nxt = 3'd0;
        for (int k = 7; k >= 0; k--) begin
            if (rem[k]) nxt = 3'(k);
        end
        more = |(rem & ~(8'd1 << nxt));
    end

    always_ff @(posedge i_clk) begin
        r_key_q <= r_key_mem[r_ctr[IW-1:0]];
        r_msk_q <= r_msk_mem[r_ctr[IW-1:0]];
        if (r_state == S_ACT && r_cmd == mrt_pkg::CMD_ADD && port_ok) begin
            if (r_hit) begin
                r_msk_mem[r_hit_i] <= r_mask | (8'd1 << r_port);
            end else if (r_free_ok) begin
                r_msk_mem[r_free_i] <= 8'd1 << r_port;
                r_key_mem[r_free_i] <= r_key;
            end
        end else if (r_state == S_ACT && r_cmd == mrt_pkg::CMD_DEL && r_hit && port_ok) begin
            r_msk_mem[r_hit_i] <= r_mask & ~(8'd1 << r_port);
        end
    end

    always_comb begin
        e_valid = 1'b0;
        e_res   = '0;
        e_res.last = 1'b1;
        e_res.status = mrt_pkg::ST_OK;
        if (r_state == S_ACT) begin
            case (r_cmd)
                mrt_pkg::CMD_ADD: begin
                    e_valid = 1'b1;
                    if (!port_ok) e_res.status = mrt_pkg::ST_NOT_FOUND;
                    else if (r_hit) e_res.port_mask = r_mask | (8'd1 << r_port);
                    else if (r_free_ok) e_res.port_mask = 8'd1 << r_port;
                    else e_res.status = mrt_pkg::ST_FULL;
                end
                mrt_pkg::CMD_DEL: begin
                    e_valid = 1'b1;
                    if (!port_ok || !r_hit) e_res.status = mrt_pkg::ST_NOT_FOUND;
                    else e_res.port_mask = r_mask & ~(8'd1 << r_port);
                end
                mrt_pkg::CMD_REPL: begin
                    e_valid = !r_hit;
                    e_res.status = mrt_pkg::ST_NOT_FOUND;
                end
                mrt_pkg::CMD_FLUSH, mrt_pkg::CMD_COUNT: e_valid = 1'b1;
                mrt_pkg::CMD_SETP: begin
                    e_valid = 1'b1;
                    if (!port_ok) e_res.status = mrt_pkg::ST_NOT_FOUND;
                end
                default: begin
                    e_valid = 1'b1;
                    e_res.status = mrt_pkg::ST_NOT_FOUND;
                end
            endcase
        end else if (r_state == S_EMIT) begin
            e_valid = 1'b1;
            e_res.port_mask = r_mask;
            if (rem != 8'd0) begin
                e_res.out_port = nxt;
                e_res.out_vlan = r_pvlan[nxt[PW-1:0]];
                e_res.status = (e_res.out_vlan != 12'd0) ? mrt_pkg::ST_OK : mrt_pkg::ST_UNREG;
                e_res.last = !more;
            end
        end
    end

    // use count as seen by the result: updated with the command
    logic [CW-1:0] res_cnt;
    always_comb begin
        res_cnt = r_used;
        if (r_state == S_ACT) begin
            if (r_cmd == mrt_pkg::CMD_ADD && port_ok && !r_hit && r_free_ok)
                res_cnt = r_used + CW'(1);
            else if (r_cmd == mrt_pkg::CMD_DEL && port_ok && r_hit
                     && (r_mask & ~(8'd1 << r_port)) == 8'd0)
                res_cnt = r_used - CW'(1);
            else if (r_cmd == mrt_pkg::CMD_FLUSH)
                res_cnt = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_vld   <= '0;
            r_used  <= '0;
            r_rdv   <= 1'b0;
            for (int p = 0; p < PL; p++) begin
                r_pmac[p]  <= '0;
                r_pvlan[p] <= '0;
            end
        end else begin
            case (r_state)
                S_IDLE: if (s_axis_tvalid) begin
                    r_cmd  <= mrt_pkg::t_cmd'(s_axis_tuser);
                    r_key  <= s_axis_tdata[59:0];
                    r_port <= s_axis_tdata[62:60];
                    r_src  <= s_axis_tdata[110:63];
                    r_pv   <= s_axis_tdata[122:111] & mrt_pkg::VLAN_MASK;
                    r_ctr  <= '0;
                    r_rdv  <= 1'b0;
                    r_hit  <= 1'b0;
                    r_free_ok <= 1'b0;
                    r_hit_i <= '0;
                    r_free_i <= '0;
                    r_mask <= '0;
                    if (s_axis_tuser inside {mrt_pkg::CMD_ADD, mrt_pkg::CMD_DEL,
                                             mrt_pkg::CMD_REPL})
                        r_state <= S_SCAN;
                    else
                        r_state <= S_ACT;
                end
                S_SCAN: begin
                    // check entry read last cycle
                    if (r_rdv) begin
                        if (r_vld[r_rd[IW-1:0]] && r_key_q == r_key && !r_hit) begin
                            r_hit <= 1'b1;
                            r_hit_i <= r_rd[IW-1:0];
                            r_mask <= r_msk_q;
                        end
                        if (!r_vld[r_rd[IW-1:0]] && !r_free_ok) begin
                            r_free_ok <= 1'b1;
                            r_free_i <= r_rd[IW-1:0];
                        end
                    end
                    r_rd  <= r_ctr;
                    if (32'(r_ctr) < TABLE_ENTRIES) begin
                        r_rdv <= 1'b1;
                        r_ctr <= r_ctr + CW'(1);
                    end else begin
                        r_rdv <= 1'b0;
                        if (!r_rdv) r_state <= S_ACT;
                    end
                end
                S_ACT: if (e_valid ? ob_ready : 1'b1) begin
                    r_used <= res_cnt;
                    case (r_cmd)
                        mrt_pkg::CMD_ADD:
                            if (port_ok && !r_hit && r_free_ok) r_vld[r_free_i] <= 1'b1;
                        mrt_pkg::CMD_DEL:
                            if (port_ok && r_hit && (r_mask & ~(8'd1 << r_port)) == 8'd0)
                                r_vld[r_hit_i] <= 1'b0;
                        mrt_pkg::CMD_FLUSH: r_vld <= '0;
                        mrt_pkg::CMD_SETP:
                            if (port_ok) begin
                                r_pmac[r_port[PW-1:0]]  <= r_key[47:0];
                                r_pvlan[r_port[PW-1:0]] <= r_pv;
                            end
                        default: ;
                    endcase
                    if (r_cmd == mrt_pkg::CMD_REPL && r_hit) begin
                        r_pi  <= '0;
                        r_sel <= '0;
                        r_state <= S_REPL;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_REPL: begin
                    // one port per cycle: member and source check
                    if (32'(r_pi) < PL) begin
                        if (r_mask[r_pi[2:0]] && r_pmac[r_pi[PW-1:0]] != r_src)
                            r_sel[r_pi[2:0]] <= 1'b1;
                        r_pi <= r_pi + 4'd1;
                    end else begin
                        r_pi <= '0;
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: if (ob_ready) begin
                    if (rem == 8'd0 || !more) r_state <= S_IDLE;
                    else r_pi <= {1'b0, nxt} + 4'd1;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    mrt_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (e_valid),
        .o_ready (ob_ready),
        .i_res   (e_res),
        .i_count (6'(res_cnt)),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_res   (o_res),
        .o_count (o_cnt)
    );
    assign m_axis_tdata = {1'b0, o_cnt, o_res.port_mask, o_res.out_vlan,
                           o_res.out_port, o_res.status};
    assign m_axis_tlast = o_res.last;
endmodule
`default_nettype wire

// ===== src/mrt_checker.sv =====
`default_nettype none
module mrt_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [31:0] m_axis_tdata,
    input wire        m_axis_tlast
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output changed while stalled");
    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[31] == 1'b0)
        else $error("pad bit set");
    a_unreg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[1:0] == 2'd3 |-> m_axis_tdata[16:5] == 12'd0)
        else $error("unregistered copy with vlan");
    a_nomulti: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[1:0] == 2'd0
            || m_axis_tdata[1:0] == 2'd3)
        else $error("non-final result with error status");
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[30:25] <= 6'd32)
        else $error("use count out of range");
endmodule
bind multicast_replication_table mrt_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
);
`default_nettype wire
